// ===== hdl/huffman_tree_builder_assert.svh =====
// Assertion helpers for the tree builder.
`ifndef HUFFMAN_TREE_BUILDER_ASSERT_SVH
`define HUFFMAN_TREE_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/htb_pkg.sv =====
`timescale 1ns / 1ps

package htb_pkg;

  localparam int NSYM_DEF      = 64;
  localparam int FREQ_BITS_DEF = 16;

  localparam int IN_FREQ_W = 16;
  localparam int FREQ_W    = 22;
  localparam int ID_W      = 7;
  localparam int CNT_W     = 7;

  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_HOLD  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE = 2'd2;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [ID_W-1:0]   id;
  } key_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] count;
    key_t             key;
  } ctl_t;

  typedef struct packed {
    logic [IN_FREQ_W-1:0] freq;
    logic                 last;
  } in_t;

  typedef struct packed {
    logic              tree_valid;
    logic [ID_W-1:0]   parent_id;
    logic [ID_W-1:0]   left_id;
    logic [ID_W-1:0]   right_id;
    logic [FREQ_W-1:0] parent_freq;
    logic              final_res;
  } out_t;

  // a orders before b: lower frequency, then lower id
  function automatic logic key_lt(key_t a, key_t b);
    return {a.freq, a.id} < {b.freq, b.id};
  endfunction

endpackage

// ===== hdl/htb_cell.sv =====
`timescale 1ns / 1ps

module htb_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  htb_pkg::ctl_t ctl,
  input  htb_pkg::key_t prev_key,
  input  logic          prev_gt,
  input  htb_pkg::key_t next1_key,
  input  htb_pkg::key_t next2_key,
  output logic          gt,
  output htb_pkg::key_t key
);

  htb_pkg::key_t key_r;
  htb_pkg::key_t key_nxt;
  logic          own_valid;
  logic          next2_valid;

  assign own_valid   = htb_pkg::CNT_W'(IDX) < ctl.count;
  assign next2_valid = htb_pkg::CNT_W'(IDX + 2) < ctl.count;

  always_comb begin
    case (ctl.op)
      htb_pkg::OP_LOAD: begin
        gt = !own_valid || htb_pkg::key_lt(ctl.key, key_r);
      end
      htb_pkg::OP_MERGE: begin
        gt = !next2_valid || htb_pkg::key_lt(ctl.key, next2_key);
      end
      default: begin
        gt = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (ctl.op)
      htb_pkg::OP_LOAD: begin
        if (prev_gt) key_nxt = prev_key;
        else if (gt) key_nxt = ctl.key;
        else key_nxt = key_r;
      end
      htb_pkg::OP_MERGE: begin
        if (prev_gt) key_nxt = next1_key;
        else if (gt) key_nxt = ctl.key;
        else key_nxt = next2_key;
      end
      default: begin
        key_nxt = key_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;

endmodule

// ===== hdl/htb_chain.sv =====
`timescale 1ns / 1ps

module htb_chain #(
  parameter int NSYM = htb_pkg::NSYM_DEF
) (
  input  logic          clk,
  input  htb_pkg::ctl_t ctl,
  output htb_pkg::key_t head0,
  output htb_pkg::key_t head1
);

  htb_pkg::key_t keys [NSYM+2];
  logic          gts  [NSYM+1];

  assign keys[NSYM]     = '0;
  assign keys[NSYM + 1] = '0;
  assign gts[0]         = 1'b0;

  for (genvar i = 0; i < NSYM; i++) begin : g_cell
    htb_pkg::key_t prev_key;

    if (i == 0) begin : g_head
      assign prev_key = keys[0];
    end else begin : g_body
      assign prev_key = keys[i-1];
    end

    htb_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .prev_key (prev_key),
      .prev_gt  (gts[i]),
      .next1_key(keys[i+1]),
      .next2_key(keys[i+2]),
      .gt       (gts[i+1]),
      .key      (keys[i])
    );
  end

  assign head0 = keys[0];
  assign head1 = keys[1];

endmodule

// ===== hdl/huffman_tree_builder.sv =====
// Huffman tree builder.
// Input channel (in_valid/in_ready/in_data): one symbol frequency per request,
// symbols numbered by arrival; zero frequencies are skipped, symbols past NSYM
// are dropped. in_data.last ends the alphabet and starts construction.
// Nodes sit in a row of NSYM cells kept sorted by (frequency, id). A load
// inserts a node in sorted place; a merge pops the two head cells and inserts
// the parent in sorted place.
// Output channel (out_valid/out_ready/out_data): one request per merge,
// parent id NSYM + merge number; final_res marks the root. With fewer than two
// nonzero symbols a single request with tree_valid 0 is sent instead.
// After the last symbol is taken, state_r enters merge and each merge record is
// registered in out_data_r; the no-tree record appears right after the last
// symbol is taken. K active nodes yield K-1 records.
// Each accepted nonzero symbol is loaded into the cell row; in_ready is low during construction.
// Stall: a low out_ready holds the output register, freezes the cell row and
// keeps in_ready low while a record waits.
// Reset: clears node count, symbol count and the pending output; cell contents
// are not cleared and are only read below the node count.
`timescale 1ns / 1ps

module huffman_tree_builder #(
  parameter int NSYM      = htb_pkg::NSYM_DEF,
  parameter int FREQ_BITS = htb_pkg::FREQ_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  htb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output htb_pkg::out_t out_data
);

  `include "huffman_tree_builder_assert.svh"

  localparam int EFF_BITS = (FREQ_BITS > htb_pkg::IN_FREQ_W) ? htb_pkg::IN_FREQ_W : FREQ_BITS;
  localparam logic [htb_pkg::IN_FREQ_W-1:0] FMASK =
    htb_pkg::IN_FREQ_W'((17'd1 << EFF_BITS) - 17'd1);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic                      state_r;
  logic [htb_pkg::CNT_W-1:0] count_r;
  logic [htb_pkg::CNT_W-1:0] sym_r;
  logic [htb_pkg::ID_W-1:0]  merge_r;
  logic                      out_valid_r;
  htb_pkg::out_t             out_data_r;
  htb_pkg::out_t             out_data_nxt;

  logic                      out_free;
  logic                      in_fire;
  logic                      take;
  logic                      ins;
  logic                      do_merge;
  logic                      empty_tree;
  logic [htb_pkg::IN_FREQ_W-1:0] fval;
  logic [htb_pkg::CNT_W-1:0] count_ins;
  logic [htb_pkg::CNT_W-1:0] count_dec;
  logic [htb_pkg::FREQ_W:0]  sum;
  htb_pkg::key_t             load_key;
  htb_pkg::key_t             parent_key;
  htb_pkg::key_t             head0;
  htb_pkg::key_t             head1;
  htb_pkg::ctl_t             ctl;
  logic                      heads_ordered;
  logic                      has_two;
  logic                      mid_merge;
  logic                      root_merge;
  logic                      load_done;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_LOAD) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign fval      = in_data.freq & FMASK;
  assign take      = in_fire && (sym_r < htb_pkg::CNT_W'(NSYM));
  assign ins       = take && (fval != '0);
  assign count_ins = ins ? count_r + htb_pkg::CNT_W'(1) : count_r;
  assign count_dec = count_r - htb_pkg::CNT_W'(1);
  assign empty_tree = count_ins < htb_pkg::CNT_W'(2);

  assign load_key.freq = htb_pkg::FREQ_W'(fval);
  assign load_key.id   = htb_pkg::ID_W'(sym_r);

  assign do_merge = (state_r == ST_MERGE) && out_free;

  assign sum = {1'b0, head0.freq} + {1'b0, head1.freq};
  assign parent_key.freq = sum[htb_pkg::FREQ_W] ? htb_pkg::FREQ_MAX : sum[htb_pkg::FREQ_W-1:0];
  assign parent_key.id   = htb_pkg::ID_W'(NSYM) + merge_r;

  always_comb begin
    ctl.count = count_r;
    if (ins) begin
      ctl.op  = htb_pkg::OP_LOAD;
      ctl.key = load_key;
    end else if (do_merge) begin
      ctl.op  = htb_pkg::OP_MERGE;
      ctl.key = parent_key;
    end else begin
      ctl.op  = htb_pkg::OP_HOLD;
      ctl.key = parent_key;
    end
  end

  htb_chain #(
    .NSYM(NSYM)
  ) u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head0(head0),
    .head1(head1)
  );

  always_comb begin
    out_data_nxt = out_data_r;
    if (do_merge) begin
      out_data_nxt.tree_valid  = 1'b1;
      out_data_nxt.parent_id   = parent_key.id;
      out_data_nxt.left_id     = head0.id;
      out_data_nxt.right_id    = head1.id;
      out_data_nxt.parent_freq = parent_key.freq;
      out_data_nxt.final_res   = count_r == htb_pkg::CNT_W'(2);
    end else if (in_fire && in_data.last && empty_tree) begin
      out_data_nxt = '0;
      out_data_nxt.final_res = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      sym_r       <= '0;
      merge_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire && in_data.last && empty_tree) begin
        out_valid_r <= 1'b1;
      end else if (do_merge) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        if (in_data.last) begin
          sym_r <= '0;
          if (empty_tree) begin
            count_r <= '0;
          end else begin
            count_r <= count_ins;
            state_r <= ST_MERGE;
            merge_r <= '0;
          end
        end else begin
          count_r <= count_ins;
          if (take) sym_r <= sym_r + htb_pkg::CNT_W'(1);
        end
      end else if (do_merge) begin
        merge_r <= merge_r + htb_pkg::ID_W'(1);
        if (count_r == htb_pkg::CNT_W'(2)) begin
          state_r <= ST_LOAD;
          count_r <= '0;
        end else begin
          count_r <= count_dec;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign heads_ordered = htb_pkg::key_lt(head0, head1);
  assign has_two       = count_r >= htb_pkg::CNT_W'(2);
  assign mid_merge     = do_merge && (count_r > htb_pkg::CNT_W'(2));
  assign root_merge    = do_merge && (count_r == htb_pkg::CNT_W'(2));
  assign load_done     = (state_r == ST_LOAD) && (count_r == '0) && out_data_r.final_res;

  `HTB_ASSERT_NOW(a_merge_has_two, state_r == ST_MERGE, has_two, "merge below two nodes")
  `HTB_ASSERT_NOW(a_heads_sorted, state_r == ST_MERGE, heads_ordered, "cell row out of order")
  `HTB_ASSERT_NEXT(a_count_drop, mid_merge, count_r == $past(count_dec), "merge count off")
  `HTB_ASSERT_NEXT(a_root_done, root_merge, load_done, "root did not end construction")

endmodule
